@@ hw/rtl/stdp_trace_weight_update_macros.svh @@
// Assertion macros for the STDP trace and weight update block.
// Used by the top level; expects clk and rst in scope.
`ifndef STDP_TRACE_WEIGHT_UPDATE_MACROS_SVH
`define STDP_TRACE_WEIGHT_UPDATE_MACROS_SVH
// same-cycle implication
`define STDPU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stdpu assertion failed");
// next-cycle implication
`define STDPU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stdpu assertion failed");
`endif

@@ hw/rtl/stdpu_pkg.sv @@
// Types and constants for the STDP trace and weight update block.
// No dependencies.
`default_nettype none
package stdpu_pkg;
  typedef enum logic [1:0] {
    KIND_POST = 2'd0,
    KIND_PRE  = 2'd1,
    KIND_SYN  = 2'd2,
    KIND_LOAD = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_LTP_DECAY = 3'd0,
    REG_LTD_DECAY = 3'd1,
    REG_POT_GAIN  = 3'd2,
    REG_DEP_GAIN  = 3'd3,
    REG_STEP      = 3'd4,
    REG_FLOOR     = 3'd5,
    REG_CEILING   = 3'd6,
    REG_DEAD      = 3'd7
  } reg_idx_t;

  localparam int QDEPTH = 4;
  localparam int QA     = 2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         neuron_index;
    logic [9:0]         post_index;
    logic [15:0]        synapse_index;
    logic [15:0]        activity;
    logic signed [15:0] load_weight;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] weight_out;
    logic [15:0]        trace_out;
    logic               dead_skip;
    logic               trace_saturated;
  } out_item_t;

  typedef struct packed {
    kind_t              kind;
    logic               ok;
    logic [9:0]         n;
    logic [9:0]         p;
    logic [15:0]        s;
    logic [15:0]        act;
    logic signed [15:0] lw;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        ltp_decay;
    logic [15:0]        ltd_decay;
    logic [15:0]        pot_gain;
    logic [15:0]        dep_gain;
    logic [15:0]        step;
    logic signed [15:0] floor_w;
    logic signed [15:0] ceil_w;
    logic signed [15:0] dead_thr;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic res_fire;
    logic out_busy;
  } back_stat_t;
endpackage
`default_nettype wire

@@ hw/rtl/stdpu_front.sv @@
// Front end: takes input transfers, range-checks and classifies them.
// Depends on stdpu_pkg.
`default_nettype none
module stdpu_front import stdpu_pkg::*; #(
  parameter int PRE_NEURONS  = 1024,
  parameter int POST_NEURONS = 1024,
  parameter int SYNAPSES     = 65536
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  input  wire logic     clearing,
  output logic          q_push,
  output cmd_t          q_cmd,
  input  wire logic     q_full
);
  logic fv, fv_next, accept, advance;
  cmd_t fcmd, ccmd;
  logic n_pre, n_post, p_post, s_ok;

  assign full    = clearing || (fv && q_full);
  assign accept  = push && !full;
  assign advance = fv && !q_full;
  assign q_push  = advance;
  assign q_cmd   = fcmd;

  always_comb begin
    n_pre  = 32'(in_item.neuron_index) < PRE_NEURONS;
    n_post = 32'(in_item.neuron_index) < POST_NEURONS;
    p_post = 32'(in_item.post_index) < POST_NEURONS;
    s_ok   = 32'(in_item.synapse_index) < SYNAPSES;
    ccmd.kind = kind_t'(in_item.kind);
    ccmd.n    = in_item.neuron_index;
    ccmd.p    = in_item.post_index;
    ccmd.s    = in_item.synapse_index;
    ccmd.act  = in_item.activity;
    ccmd.lw   = in_item.load_weight;
    case (ccmd.kind)
      KIND_POST: ccmd.ok = n_post;
      KIND_PRE:  ccmd.ok = n_pre;
      KIND_SYN:  ccmd.ok = n_pre && p_post && s_ok;
      KIND_LOAD: ccmd.ok = s_ok;
      default:   ccmd.ok = 1'b0;
    endcase
  end

  always_comb begin
    fv_next = fv;
    if (accept) begin
      fv_next = 1'b1;
    end else if (advance) begin
      fv_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= fv_next;
    end
    if (accept) begin
      fcmd <= ccmd;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/stdpu_fifo.sv @@
// Short command queue between front and back ends.
// Depends on stdpu_pkg.
`default_nettype none
module stdpu_fifo import stdpu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wdata,
  output logic      q_full,
  input  wire logic rd,
  output cmd_t      rdata,
  output logic      q_empty
);
  cmd_t entries [QDEPTH];
  logic [QA-1:0] wr_ptr, rd_ptr;
  logic [QA:0]   cnt;
  logic do_wr, do_rd;

  assign q_full  = cnt == (QA+1)'(QDEPTH);
  assign q_empty = cnt == '0;
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
    if (do_wr) begin
      entries[wr_ptr] <= wdata;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/stdpu_back.sv @@
// Back end: trace and weight memories, multiply sequencer, result register.
// Depends on stdpu_pkg.
`default_nettype none
module stdpu_back import stdpu_pkg::*; #(
  parameter int PRE_NEURONS  = 1024,
  parameter int POST_NEURONS = 1024,
  parameter int SYNAPSES     = 65536
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire cmd_t head,
  input  wire logic q_empty,
  output logic      q_pop,
  output logic      empty,
  input  wire logic pop,
  output out_item_t out_item,
  output back_stat_t stat
);
  localparam int PA   = $clog2(PRE_NEURONS);
  localparam int OA   = $clog2(POST_NEURONS);
  localparam int SA   = $clog2(SYNAPSES);
  localparam int MAXN = (PRE_NEURONS > POST_NEURONS) ? PRE_NEURONS : POST_NEURONS;
  localparam int CW   = $clog2(MAXN + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL1  = 6'b000100,
    S_MUL2  = 6'b001000,
    S_MUL3  = 6'b010000,
    S_WB    = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [31:0] pre_mem  [PRE_NEURONS];
  logic [31:0] post_mem [POST_NEURONS];
  logic [15:0] w_mem    [SYNAPSES];

  cmd_t cmd;
  logic [PA-1:0] pre_addr;
  logic [OA-1:0] post_addr;
  logic [SA-1:0] w_addr;
  logic [31:0] pre_rd, post_rd;
  logic signed [15:0] w_rd;
  logic [31:0] m_ltp1, m_ltd1, m_dec, ltp, ltd;
  logic signed [49:0] dprod;
  logic [CW-1:0] clr_cnt;
  logic out_valid;
  out_item_t out_reg, res;

  logic can_out, syn_go, fire2, firewb, dead;
  logic [47:0] ltp_full, ltd_full;
  logic [15:0] tr_old, decay;
  logic [16:0] tsum;
  logic [15:0] tr_new;
  logic signed [32:0] diff;
  logic signed [38:0] wsum;
  logic signed [15:0] wnew;

  assign can_out  = !out_valid || pop;
  assign syn_go   = cmd.kind == KIND_SYN && cmd.ok;
  assign fire2    = state == S_MUL2 && !syn_go && can_out;
  assign firewb   = state == S_WB && can_out;
  assign q_pop    = state == S_IDLE && !q_empty;
  assign empty    = !out_valid;
  assign out_item = out_reg;
  assign stat.clearing = state == S_CLEAR;
  assign stat.res_fire = fire2 || firewb;
  assign stat.out_busy = out_valid;

  always_comb begin
    tr_old   = (cmd.kind == KIND_PRE) ? pre_rd[15:0] : post_rd[15:0];
    decay    = (cmd.kind == KIND_PRE) ? cfg.ltp_decay : cfg.ltd_decay;
    ltp_full = 48'(m_ltp1) * 48'(pre_rd[15:0]);
    ltd_full = 48'(m_ltd1) * 48'(post_rd[15:0]);
    tsum     = {1'b0, m_dec[31:16]} + {1'b0, cmd.act};
    tr_new   = tsum[16] ? 16'hFFFF : tsum[15:0];
    diff     = $signed({1'b0, ltp}) - $signed({1'b0, ltd});
    dead     = w_rd < cfg.dead_thr;
    wsum     = 39'(w_rd) + 39'(dprod >>> 12);
    if (wsum < 39'(cfg.floor_w)) wsum = 39'(cfg.floor_w);
    if (wsum > 39'(cfg.ceil_w)) wsum = 39'(cfg.ceil_w);
    wnew     = dead ? w_rd : wsum[15:0];
    res      = '0;
    if (state == S_WB) begin
      res.weight_out = wnew;
      res.dead_skip  = dead;
    end else if (cmd.ok) begin
      case (cmd.kind)
        KIND_POST, KIND_PRE: begin
          res.trace_out       = tr_new;
          res.trace_saturated = tsum[16];
        end
        KIND_LOAD: res.weight_out = cmd.lw;
        default:   res = '0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == CW'(MAXN - 1)) state_next = S_IDLE;
      S_IDLE:  if (!q_empty) state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2: begin
        if (syn_go) begin
          state_next = S_MUL3;
        end else if (can_out) begin
          state_next = S_IDLE;
        end
      end
      S_MUL3:  state_next = S_WB;
      S_WB:    if (can_out) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (fire2 || firewb) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
    if (fire2 || firewb) out_reg <= res;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd       <= head;
      pre_addr  <= PA'(head.n);
      post_addr <= (head.kind == KIND_POST) ? OA'(head.n) : OA'(head.p);
      w_addr    <= SA'(head.s);
      pre_rd    <= pre_mem[PA'(head.n)];
      post_rd   <= post_mem[(head.kind == KIND_POST) ? OA'(head.n) : OA'(head.p)];
      w_rd      <= w_mem[SA'(head.s)];
    end
    if (state == S_MUL1) begin
      m_ltp1 <= 32'(cfg.pot_gain) * 32'(post_rd[31:16]);
      m_ltd1 <= 32'(cfg.dep_gain) * 32'(pre_rd[31:16]);
      m_dec  <= 32'(decay) * 32'(tr_old);
    end
    if (state == S_MUL2) begin
      ltp <= ltp_full[47:16];
      ltd <= ltd_full[47:16];
    end
    if (state == S_MUL3) begin
      dprod <= 50'(diff) * 50'($signed({1'b0, cfg.step}));
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (32'(clr_cnt) < PRE_NEURONS) pre_mem[clr_cnt[PA-1:0]] <= '0;
    end else if (fire2 && cmd.ok && cmd.kind == KIND_PRE) begin
      pre_mem[pre_addr] <= {cmd.act, tr_new};
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (32'(clr_cnt) < POST_NEURONS) post_mem[clr_cnt[OA-1:0]] <= '0;
    end else if (fire2 && cmd.ok && cmd.kind == KIND_POST) begin
      post_mem[post_addr] <= {cmd.act, tr_new};
    end
  end

  always_ff @(posedge clk) begin
    if (fire2 && cmd.ok && cmd.kind == KIND_LOAD) begin
      w_mem[w_addr] <= cmd.lw;
    end else if (firewb && !dead) begin
      w_mem[w_addr] <= wnew;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/stdp_trace_weight_update.sv @@
// Top level of the STDP trace and weight update block: config registers,
// front end, command queue, back end. Depends on stdpu_pkg and the macros header.
//
//  channel  handshake             payload
//  input    push / full           in_item   (in_item_t)
//  result   pop / empty           out_item  (out_item_t)
//  config   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Pre/post samples, loads and out-of-range items pass the back-end states
// S_IDLE, S_MUL1 and S_MUL2; synapse updates add S_MUL3 and S_WB. All use the
// shared multiply sequencer. After reset a clearing pass zeroes the trace
// memories; full stays high meanwhile. Config is always ready.
// A waiting result stalls only the back end; the queue takes items until full.
`default_nettype none
`include "stdp_trace_weight_update_macros.svh"
module stdp_trace_weight_update import stdpu_pkg::*; #(
  parameter int PRE_NEURONS  = 1024,
  parameter int POST_NEURONS = 1024,
  parameter int SYNAPSES     = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire reg_idx_t    cfg_index,
  input  wire logic [15:0] cfg_data
);
  cfg_t cfg;
  logic q_push, q_full, q_empty, q_pop;
  cmd_t q_in, q_out;
  back_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ltp_decay <= 16'd62367;
      cfg.ltd_decay <= 16'd62367;
      cfg.pot_gain  <= 16'd4096;
      cfg.dep_gain  <= 16'd4506;
      cfg.step      <= 16'd4096;
      cfg.floor_w   <= 16'sd0;
      cfg.ceil_w    <= 16'sd4096;
      cfg.dead_thr  <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LTP_DECAY: cfg.ltp_decay <= cfg_data;
        REG_LTD_DECAY: cfg.ltd_decay <= cfg_data;
        REG_POT_GAIN:  cfg.pot_gain  <= cfg_data;
        REG_DEP_GAIN:  cfg.dep_gain  <= cfg_data;
        REG_STEP:      cfg.step      <= cfg_data;
        REG_FLOOR:     cfg.floor_w   <= cfg_data;
        REG_CEILING:   cfg.ceil_w    <= cfg_data;
        REG_DEAD:      cfg.dead_thr  <= cfg_data;
        default:       cfg.step      <= cfg.step;
      endcase
    end
  end

  stdpu_front #(
    .PRE_NEURONS(PRE_NEURONS), .POST_NEURONS(POST_NEURONS), .SYNAPSES(SYNAPSES)
  ) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .clearing(stat.clearing), .q_push(q_push), .q_cmd(q_in), .q_full(q_full)
  );

  stdpu_fifo u_fifo (
    .clk(clk), .rst(rst), .wr(q_push), .wdata(q_in), .q_full(q_full),
    .rd(q_pop), .rdata(q_out), .q_empty(q_empty)
  );

  stdpu_back #(
    .PRE_NEURONS(PRE_NEURONS), .POST_NEURONS(POST_NEURONS), .SYNAPSES(SYNAPSES)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(q_out), .q_empty(q_empty),
    .q_pop(q_pop), .empty(empty), .pop(pop), .out_item(out_item), .stat(stat)
  );

  `STDPU_ASSERT_IMP(a_clear_blocks_input, stat.clearing, full)
  `STDPU_ASSERT_IMP(a_no_result_overwrite, stat.res_fire, !stat.out_busy || pop)
  `STDPU_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full)
  `STDPU_ASSERT_NXT(a_result_shown, stat.res_fire, !empty)
endmodule
`default_nettype wire
